[sv/llr_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, codes, pipeline depths and elaboration-time root constants
// for the log-logistic response pipeline. No dependencies.
package llr_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned SLOPE_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned LOG_W     = 21;
  localparam int unsigned T_W       = 22;
  localparam int unsigned PROD_W    = SLOPE_W + T_W;
  localparam int unsigned W_W       = 31;
  localparam int unsigned MAG_W     = DATA_W + W_W;

  localparam int unsigned LOG_STAGES = 17;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned DIV_STEPS  = 31;
  localparam int unsigned WGT_STAGES = 1 + FRAC_BITS + 1 + DIV_STEPS;
  localparam int unsigned PIPE_DEPTH = LOG_STAGES + 2 + WGT_STAGES + 2;

  localparam logic signed [DATA_W-1:0] LOW_RST   = 32'sd0;
  localparam logic signed [DATA_W-1:0] HIGH_RST  = 32'sd65536;
  localparam logic [DATA_W-1:0]        ED50_RST  = 32'd655360;
  localparam logic signed [SLOPE_W-1:0] SLOPE_RST = 16'sd512;

  typedef enum logic [1:0] {
    KIND_CURVE = 2'd0,
    KIND_MID   = 2'd1,
    KIND_LOW   = 2'd2,
    KIND_HIGH  = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW   = 2'd0,
    CFG_HIGH  = 2'd1,
    CFG_ED50  = 2'd2,
    CFG_SLOPE = 2'd3
  } cfg_idx_e;

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] b;
    rem = v;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (b > rem) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (rem >= res + b) begin
          rem = rem - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
    end
    return res;
  endfunction

  // 2^(2^-k) in Q2.30
  function automatic logic [31:0] exp2_root(int k);
    logic [63:0] r;
    r = 64'h8000_0000;
    for (int i = 1; i <= k; i++) begin
      r = isqrt64(r << 30);
    end
    return r[31:0];
  endfunction

endpackage

[sv/llr_log2.sv]
`timescale 1ns / 1ps
// Pipelined fixed-point log2: normalize, then one squaring step per stage.
// Depends on llr_pkg.
module llr_log2 import llr_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [DATA_W-1:0] x_i,
  output logic [LOG_W-1:0]  log_o
);

  logic [4:0]  top_bit;
  logic [61:0] norm;

  always_comb begin
    top_bit = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (x_i[i]) top_bit = 5'(i);
    end
    norm = {x_i, 30'b0} >> top_bit;
  end

  logic [30:0] y_q [LOG_STAGES];
  logic [4:0]  n_q [LOG_STAGES];
  logic [15:0] f_q [LOG_STAGES];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q[0] <= norm[30:0];
      n_q[0] <= top_bit;
      f_q[0] <= '0;
    end
  end

  for (genvar g = 1; g < LOG_STAGES; g++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] s;
    assign sq = 62'(y_q[g-1]) * 62'(y_q[g-1]);
    assign s  = sq[61:30];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        y_q[g] <= s[31] ? s[31:1] : s[30:0];
        f_q[g] <= {f_q[g-1][14:0], s[31]};
        n_q[g] <= n_q[g-1];
      end
    end
  end

  assign log_o = {n_q[LOG_STAGES-1], f_q[LOG_STAGES-1]};

endmodule

[sv/llr_weight.sv]
`timescale 1ns / 1ps
// Pipelined weight 1/(1+2^e): exp2 by constant roots, scale, then a
// restoring divider one quotient bit per stage. Depends on llr_pkg.
module llr_weight import llr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [PROD_W-1:0] prod_i,
  output logic [W_W-1:0]           w_o
);

  logic signed [13:0] ei;
  assign ei = prod_i[PROD_W-1:24];

  logic [15:0]        ef_q   [FRAC_BITS];
  logic signed [13:0] ei_q   [FRAC_BITS+1];
  logic [31:0]        m_q    [FRAC_BITS+1];
  logic               big_q  [WGT_STAGES];
  logic               tiny_q [WGT_STAGES];
  logic [61:0]        r_q    [DIV_STEPS+1];
  logic [30:0]        nlo_q  [DIV_STEPS+1];
  logic [61:0]        d_q    [DIV_STEPS+1];
  logic [30:0]        quo_q  [DIV_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ef_q[0]   <= prod_i[23:8];
      ei_q[0]   <= ei;
      m_q[0]    <= 32'h4000_0000;
      big_q[0]  <= ei >= 14'sd31;
      tiny_q[0] <= ei <= -14'sd31;
    end
  end

  for (genvar g = 1; g < WGT_STAGES; g++) begin : g_flag
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        big_q[g]  <= big_q[g-1];
        tiny_q[g] <= tiny_q[g-1];
      end
    end
  end

  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_exp
    localparam logic [31:0] ROOT = exp2_root(k);
    logic [63:0] pr;
    assign pr = 64'(m_q[k-1]) * 64'(ROOT);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[k]  <= ef_q[k-1][FRAC_BITS-k] ? pr[61:30] : m_q[k-1];
        ei_q[k] <= ei_q[k-1];
      end
    end
    if (k < FRAC_BITS) begin : g_ef
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          ef_q[k] <= ef_q[k-1];
        end
      end
    end
  end

  logic [13:0] neg_ei;
  logic [61:0] pval;
  logic [61:0] dval;
  logic [61:0] nval;

  always_comb begin
    neg_ei = -ei_q[FRAC_BITS];
    if (ei_q[FRAC_BITS] >= 0) begin
      pval = {30'b0, m_q[FRAC_BITS]} << ei_q[FRAC_BITS][4:0];
    end else begin
      pval = {30'b0, m_q[FRAC_BITS]} >> neg_ei[4:0];
    end
    dval = 62'h4000_0000 + pval;
    nval = 62'h1000_0000_0000_0000 + (dval >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= {31'b0, nval[61:31]};
      nlo_q[0] <= nval[30:0];
      d_q[0]   <= dval;
      quo_q[0] <= '0;
    end
  end

  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    logic [62:0] rt;
    logic [62:0] diff;
    logic        ge;
    assign rt   = {r_q[j-1], nlo_q[j-1][DIV_STEPS-j]};
    assign diff = rt - {1'b0, d_q[j-1]};
    assign ge   = rt >= {1'b0, d_q[j-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j]   <= ge ? diff[61:0] : rt[61:0];
        nlo_q[j] <= nlo_q[j-1];
        d_q[j]   <= d_q[j-1];
        quo_q[j] <= {quo_q[j-1][29:0], ge};
      end
    end
  end

  always_comb begin
    priority if (big_q[WGT_STAGES-1]) begin
      w_o = '0;
    end else if (tiny_q[WGT_STAGES-1]) begin
      w_o = 31'h4000_0000;
    end else begin
      w_o = quo_q[DIV_STEPS];
    end
  end

endmodule

[sv/log_logistic_response.sv]
`timescale 1ns / 1ps
// Channel   | dir | payload                       | transaction when
// s_axis    | in  | tdata[31:0] dose_level        | s_axis_tvalid & s_axis_tready
// m_axis    | out | tdata[31:0] response          | m_axis_tvalid & m_axis_tready
// cfg       | in  | cfg_idx_i, cfg_data_i         | cfg_we_i
// One transaction per cycle unless m_axis stalls: log2 squaring (17 stages),
// exponent (2), exp2 roots and divider (49), scale and saturate (2).
// Reset clears the valid bits and loads the register defaults.
// A stall on m_axis freezes every stage; s_axis_tready drops with it.
// Depends on llr_pkg, llr_log2, llr_weight.
module log_logistic_response import llr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [DATA_W-1:0]    s_axis_tdata,   // [31:0] dose_level
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [DATA_W-1:0]    m_axis_tdata,   // [31:0] response
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  logic signed [DATA_W-1:0]  low_q;
  logic signed [DATA_W-1:0]  high_q;
  logic [DATA_W-1:0]         ed50_q;
  logic signed [SLOPE_W-1:0] slope_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q   <= LOW_RST;
      high_q  <= HIGH_RST;
      ed50_q  <= ED50_RST;
      slope_q <= SLOPE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LOW:   low_q   <= cfg_data_i;
        CFG_HIGH:  high_q  <= cfg_data_i;
        CFG_ED50:  ed50_q  <= cfg_data_i;
        CFG_SLOPE: slope_q <= cfg_data_i[SLOPE_W-1:0];
        default:   ;
      endcase
    end
  end

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  kind_e kind_in;
  always_comb begin
    priority if (slope_q == '0) begin
      kind_in = KIND_MID;
    end else if (s_axis_tdata == '0) begin
      kind_in = slope_q[SLOPE_W-1] ? KIND_HIGH : KIND_LOW;
    end else begin
      kind_in = KIND_CURVE;
    end
  end

  logic  valid_q [PIPE_DEPTH];
  kind_e kind_q  [PIPE_DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIPE_DEPTH; i++) valid_q[i] <= 1'b0;
    end else if (en) begin
      valid_q[0] <= s_axis_tvalid;
      for (int i = 1; i < PIPE_DEPTH; i++) valid_q[i] <= valid_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind_q[0] <= kind_in;
      for (int i = 1; i < PIPE_DEPTH; i++) kind_q[i] <= kind_q[i-1];
    end
  end

  logic [DATA_W-1:0] ed50_eff;
  logic [LOG_W-1:0]  log_dose;
  logic [LOG_W-1:0]  log_ed50;
  assign ed50_eff = (ed50_q == '0) ? DATA_W'(1) : ed50_q;

  llr_log2 u_log_dose (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (s_axis_tdata),
    .log_o (log_dose)
  );

  llr_log2 u_log_ed50 (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (ed50_eff),
    .log_o (log_ed50)
  );

  logic signed [T_W-1:0]    t_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_d;
  assign prod_d = -(PROD_W'(slope_q) * PROD_W'(t_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q    <= T_W'(log_dose) - T_W'(log_ed50);
      prod_q <= prod_d;
    end
  end

  logic [W_W-1:0] w;
  llr_weight u_weight (
    .clk_i  (clk_i),
    .en_i   (en),
    .prod_i (prod_q),
    .w_o    (w)
  );

  logic signed [DATA_W:0] diff;
  logic [DATA_W:0]        diff_neg;
  logic [DATA_W-1:0]      abs_diff;
  assign diff     = {high_q[DATA_W-1], high_q} - {low_q[DATA_W-1], low_q};
  assign diff_neg = -diff;
  assign abs_diff = diff[DATA_W] ? diff_neg[DATA_W-1:0] : diff[DATA_W-1:0];

  logic [MAG_W-1:0] mag_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q <= MAG_W'(abs_diff) * MAG_W'(w);
    end
  end

  logic [MAG_W:0]         rnd;
  logic signed [34:0]     qs;
  logic signed [34:0]     res;
  logic [DATA_W-1:0]      res_d;
  logic [DATA_W-1:0]      res_q;

  always_comb begin
    rnd = {1'b0, mag_q} + (MAG_W+1)'(64'h2000_0000);
    qs  = diff[DATA_W] ? -$signed({2'b0, rnd[62:30]}) : $signed({2'b0, rnd[62:30]});
    unique case (kind_q[PIPE_DEPTH-2])
      KIND_MID:   res = 35'(low_q) + 35'(diff >>> 1);
      KIND_LOW:   res = 35'(low_q);
      KIND_HIGH:  res = 35'(high_q);
      KIND_CURVE: res = 35'(low_q) + qs;
      default:    res = 35'(low_q) + qs;
    endcase
    priority if (res > 35'sh0_7FFF_FFFF) begin
      res_d = 32'h7FFF_FFFF;
    end else if (res < -35'sh0_8000_0000) begin
      res_d = 32'h8000_0000;
    end else begin
      res_d = res[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = valid_q[PIPE_DEPTH-1];
  assign m_axis_tdata  = res_q;

endmodule

[sv/llr_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for log_logistic_response, bound to the top level.
// Depends on llr_pkg.
module llr_checker import llr_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [DATA_W-1:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed under stall");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !m_axis_tvalid)
    else $error("result presented right after reset");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while pipeline frozen");

endmodule

bind log_logistic_response llr_checker u_llr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
